/* src/fei_pkg.sv */
// ----------------------------------------------------------------------------
// fei_pkg
// Shared types and constants for the FASTA entry indexer.
// ----------------------------------------------------------------------------
package fei_pkg;

  // Default width of the internal offset and residue counters.
  localparam int OFFSET_BITS_DEF = 48;

  // Widths of the result channel fields and of the input byte.
  localparam int OUT_W   = 48;
  localparam int HDR_W   = 32;
  localparam int DATA_W  = 8;

  // Packed result payload: four OUT_W fields, header count, verdict, padded to bytes.
  localparam int TDATA_RAW_W = 4 * OUT_W + HDR_W + 1;
  localparam int TDATA_W     = ((TDATA_RAW_W + 7) / 8) * 8;

  // Depth of the result queue and its pointer width.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Character codes the scanner reacts to.
  localparam logic [DATA_W-1:0] CH_GT   = 8'h3E;
  localparam logic [DATA_W-1:0] CH_LF   = 8'h0A;
  localparam logic [DATA_W-1:0] CH_CR   = 8'h0D;
  localparam logic [DATA_W-1:0] CH_A    = 8'h41;
  localparam logic [DATA_W-1:0] CH_C    = 8'h43;
  localparam logic [DATA_W-1:0] CH_G    = 8'h47;
  localparam logic [DATA_W-1:0] CH_T    = 8'h54;
  localparam logic [DATA_W-1:0] CASE_MASK = 8'hDF;

  // Record kinds.
  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  // One result record.
  typedef struct packed {
    logic             rec_kind;
    logic [OUT_W-1:0] entry_length;
    logic [OUT_W-1:0] entry_start;
    logic [OUT_W-1:0] entry_end;
    logic [OUT_W-1:0] total_residues;
    logic [HDR_W-1:0] header_total;
    logic             nucleotide_like;
    logic             last_rec;
  } result_t;

  // What the scanner hands to the result queue for one byte.
  typedef struct packed {
    result_t     res_a;
    result_t     res_b;
    logic [1:0]  res_cnt;
  } core_out_t;

endpackage

/* src/fasta_entry_indexer.sv */
// ----------------------------------------------------------------------------
// fasta_entry_indexer
// Scans a FASTA byte stream and reports the span and residue count of each
// entry, plus file totals and a nucleotide verdict on the final byte.
// ----------------------------------------------------------------------------
//  Channel  Direction  tdata                         tuser        tlast
//  in_      slave      data_byte                     -            end_of_file
//  out_     master     lengths, offsets, totals      record_kind  last
//
//  Bytes enter one per cycle while in_tready is high. A byte is registered,
//  scanned once the queue has room, and its records (none, one or two) land
//  in a four-entry queue. A byte that causes two records gives two transfers.
//  Scanning stalls while the queue has fewer than two free slots.
//  rst_n is synchronous; it clears the scanner, the input stage and the queue.
// ----------------------------------------------------------------------------
module fasta_entry_indexer
  import fei_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input transfer: tdata = data_byte[7:0].
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [DATA_W-1:0]  in_tdata,
  input  logic               in_tlast,
  // Result transfer: tdata = entry_length[47:0], entry_start[95:48],
  // entry_end[143:96], total_residues[191:144], header_total[223:192],
  // nucleotide_like[224], zero padding above.
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,
  // tuser = record_kind[0].
  output logic [0:0]         out_tuser,
  output logic               out_tlast
);

  // Input register.
  logic              in_vld_r;
  logic [DATA_W-1:0] in_byte_r;
  logic              in_eof_r;
  logic              step;
  core_out_t         core_out;

  // Result queue.
  result_t           q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] q_cnt_r, q_cnt_nxt;
  logic              pop;
  logic [QPTR_W-1:0] wr_ptr_b;
  result_t           head;

  // Scan when the queue can absorb the worst case of two records.
  assign step      = in_vld_r && (q_cnt_r <= QCNT_W'(QDEPTH - 2));
  assign in_tready = !in_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_eof_r  <= in_tlast;
    end
  end

  fei_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .data_byte   (in_byte_r),
    .end_of_file (in_eof_r),
    .core_out    (core_out)
  );

  // Queue bookkeeping.
  assign pop       = (q_cnt_r != '0) && out_tready;
  assign wr_ptr_b  = wr_ptr_r + 1'b1;
  assign q_cnt_nxt = q_cnt_r + (step ? QCNT_W'(core_out.res_cnt) : '0)
                     - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (step) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(core_out.res_cnt);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      q_cnt_r <= q_cnt_nxt;
    end
  end

  // Queue storage; records are written in file order.
  always_ff @(posedge clk) begin
    if (step && (core_out.res_cnt != 2'd0)) begin
      q_mem[wr_ptr_r] <= core_out.res_a;
    end
    if (step && (core_out.res_cnt == 2'd2)) begin
      q_mem[wr_ptr_b] <= core_out.res_b;
    end
  end

  // Result channel driven from the queue head.
  assign head       = q_mem[rd_ptr_r];
  assign out_tvalid = (q_cnt_r != '0);
  assign out_tuser  = head.rec_kind;
  assign out_tlast  = head.last_rec;
  assign out_tdata  = {(TDATA_W - TDATA_RAW_W)'(0), head.nucleotide_like,
                       head.header_total, head.total_residues, head.entry_end,
                       head.entry_start, head.entry_length};

endmodule

/* src/fei_core.sv */
// ----------------------------------------------------------------------------
// fei_core
// Per-byte scanner: header flag, saturating counters, entry spans and the
// nucleotide verdict. Produces up to two records for each byte it takes.
// ----------------------------------------------------------------------------
module fei_core
  import fei_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [DATA_W-1:0] data_byte,
  input  logic              end_of_file,
  output core_out_t         core_out
);

  localparam int DW = OFFSET_BITS + 4;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [HDR_W-1:0]       HDR_MAX = {HDR_W{1'b1}};

  // Scanner state.
  logic                   in_header_r, in_header_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] span_start_r, span_start_nxt;
  logic [OFFSET_BITS-1:0] span_end_r, span_end_nxt;
  logic [OFFSET_BITS-1:0] cur_len_r, cur_len_nxt;
  logic [OFFSET_BITS-1:0] total_r, total_nxt;
  logic [OFFSET_BITS-1:0] acgt_r, acgt_nxt;
  logic [HDR_W-1:0]       hdr_cnt_r, hdr_cnt_nxt;
  // Running 4*acgt - 3*total; the verdict is its sign.
  logic signed [DW-1:0]   diff_r, diff_nxt;

  logic                   is_open, is_break, is_res, is_acgt;
  logic                   acgt_inc, total_inc, emit_entry, nuc;
  logic [DATA_W-1:0]      upper;
  logic signed [3:0]      delta;
  result_t                rec_entry, rec_final;

  // Byte classification and next-state computation.
  always_comb begin
    upper     = data_byte & CASE_MASK;
    is_open   = !in_header_r && (data_byte == CH_GT);
    is_break  = !is_open && (data_byte inside {CH_LF, CH_CR});
    is_res    = !is_open && !is_break && !in_header_r;
    is_acgt   = upper inside {CH_A, CH_C, CH_G, CH_T};
    acgt_inc  = is_res && is_acgt && (acgt_r != OFF_MAX);
    total_inc = is_res && (total_r != OFF_MAX);

    pos_nxt = (pos_r == OFF_MAX) ? pos_r : pos_r + 1'b1;

    if (is_open) begin
      in_header_nxt = 1'b1;
    end else if (is_break) begin
      in_header_nxt = 1'b0;
    end else begin
      in_header_nxt = in_header_r;
    end

    hdr_cnt_nxt = (is_open && (hdr_cnt_r != HDR_MAX)) ? hdr_cnt_r + 1'b1 : hdr_cnt_r;

    // A header opening closes the previous entry once residues exist.
    emit_entry   = is_open && (total_r != '0);
    span_end_nxt = emit_entry ? pos_nxt - 1'b1 : span_end_r;
    span_start_nxt = is_open ? span_end_nxt : span_start_r;

    if (is_open) begin
      cur_len_nxt = '0;
    end else if (is_res && (cur_len_r != OFF_MAX)) begin
      cur_len_nxt = cur_len_r + 1'b1;
    end else begin
      cur_len_nxt = cur_len_r;
    end

    total_nxt = total_inc ? total_r + 1'b1 : total_r;
    acgt_nxt  = acgt_inc ? acgt_r + 1'b1 : acgt_r;

    // Track the verdict difference only where a counter really moved.
    delta    = (acgt_inc ? 4'sd4 : 4'sd0) - (total_inc ? 4'sd3 : 4'sd0);
    diff_nxt = diff_r + DW'(delta);
    nuc      = !diff_nxt[DW-1] && (diff_nxt != '0);
  end

  // Records for this byte.
  always_comb begin
    rec_entry.rec_kind        = KIND_ENTRY;
    rec_entry.entry_length    = OUT_W'(64'(cur_len_r));
    rec_entry.entry_start     = OUT_W'(64'(span_start_r));
    rec_entry.entry_end       = OUT_W'(64'(span_end_nxt));
    rec_entry.total_residues  = '0;
    rec_entry.header_total    = '0;
    rec_entry.nucleotide_like = 1'b0;
    rec_entry.last_rec        = !end_of_file;

    rec_final.rec_kind        = KIND_FINAL;
    rec_final.entry_length    = OUT_W'(64'(cur_len_nxt));
    rec_final.entry_start     = OUT_W'(64'(span_start_nxt));
    rec_final.entry_end       = OUT_W'(64'(pos_nxt));
    rec_final.total_residues  = OUT_W'(64'(total_nxt));
    rec_final.header_total    = hdr_cnt_nxt;
    rec_final.nucleotide_like = nuc;
    rec_final.last_rec        = 1'b1;

    core_out.res_a   = emit_entry ? rec_entry : rec_final;
    core_out.res_b   = rec_final;
    core_out.res_cnt = {1'b0, emit_entry} + {1'b0, end_of_file};
  end

  // State update; the final byte of a file returns everything to reset.
  always_ff @(posedge clk) begin
    if (!rst_n || (step && end_of_file)) begin
      in_header_r  <= 1'b0;
      pos_r        <= '0;
      span_start_r <= '0;
      span_end_r   <= '0;
      cur_len_r    <= '0;
      total_r      <= '0;
      acgt_r       <= '0;
      hdr_cnt_r    <= '0;
      diff_r       <= '0;
    end else if (step) begin
      in_header_r  <= in_header_nxt;
      pos_r        <= pos_nxt;
      span_start_r <= span_start_nxt;
      span_end_r   <= span_end_nxt;
      cur_len_r    <= cur_len_nxt;
      total_r      <= total_nxt;
      acgt_r       <= acgt_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      diff_r       <= diff_nxt;
    end
  end

endmodule

/* tb/sv/tb_fasta_entry_indexer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fasta_entry_indexer
// Self-checking bench for the FASTA entry indexer. A queue of file bytes
// feeds a clocked driver, and a scoreboard predicts the entry and final
// records of every accepted byte. A clocked monitor compares each result
// transfer field by field against the oldest prediction. The run covers a
// directed set of corner cases, then randomly built files under several
// mixes of sender gaps and receiver stalls, and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_fasta_entry_indexer;
  import fei_pkg::*;

  localparam logic [OUT_W-1:0] CNT_MAX = '1;
  localparam logic [HDR_W-1:0] HDR_MAX = '1;

  // One file byte waiting to be sent.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              eof;
  } file_byte_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [DATA_W-1:0]  in_tdata;
  logic               in_tlast;
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;
  logic [0:0]         out_tuser;
  logic               out_tlast;

  file_byte_t byte_q[$];
  result_t    record_q[$];

  int src_idle_pct;
  int sink_stall_pct;
  logic sink_hold;
  int bytes_taken;
  int mismatches;

  // Scanner state mirrored by the scoreboard.
  logic             hdr_open;
  logic [OUT_W-1:0] pos_cnt;
  logic [OUT_W-1:0] ent_start;
  logic [OUT_W-1:0] ent_end;
  logic [OUT_W-1:0] ent_len;
  logic [OUT_W-1:0] res_total;
  logic [OUT_W-1:0] nuc_cnt;
  logic [HDR_W-1:0] hdr_cnt;

  fasta_entry_indexer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Clock and the single reset at the start of the run.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic logic [OUT_W-1:0] sat_inc(input logic [OUT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

  task automatic clear_scan_state();
    hdr_open  = 1'b0;
    pos_cnt   = '0;
    ent_start = '0;
    ent_end   = '0;
    ent_len   = '0;
    res_total = '0;
    nuc_cnt   = '0;
    hdr_cnt   = '0;
  endtask

  // Advances the mirrored scanner by one byte and queues the records it causes.
  task automatic scan_byte(input logic [DATA_W-1:0] b, input logic eof);
    result_t rec;
    logic [DATA_W-1:0] up;
    logic [OUT_W+1:0] three_q;
    pos_cnt = sat_inc(pos_cnt);
    if (!hdr_open && b == CH_GT) begin
      hdr_open = 1'b1;
      if (hdr_cnt != HDR_MAX) hdr_cnt = hdr_cnt + 1'b1;
      if (res_total != '0) begin
        ent_end = pos_cnt - 1'b1;
        rec = '0;
        rec.rec_kind     = KIND_ENTRY;
        rec.entry_length = ent_len;
        rec.entry_start  = ent_start;
        rec.entry_end    = ent_end;
        rec.last_rec     = !eof;
        record_q.insert(record_q.size(), rec);
      end
      ent_len   = '0;
      ent_start = ent_end;
    end else if (b == CH_LF || b == CH_CR) begin
      hdr_open = 1'b0;
    end else if (!hdr_open) begin
      up = b & CASE_MASK;
      if (up == CH_A || up == CH_C || up == CH_G || up == CH_T) nuc_cnt = sat_inc(nuc_cnt);
      ent_len   = sat_inc(ent_len);
      res_total = sat_inc(res_total);
    end
    if (eof) begin
      three_q = ({2'b00, res_total} >> 2) * 3 + ((({2'b00, res_total} & 3) * 3) >> 2);
      rec = '0;
      rec.rec_kind        = KIND_FINAL;
      rec.entry_length    = ent_len;
      rec.entry_start     = ent_start;
      rec.entry_end       = pos_cnt;
      rec.total_residues  = res_total;
      rec.header_total    = hdr_cnt;
      rec.nucleotide_like = ({2'b00, nuc_cnt} > three_q);
      rec.last_rec        = 1'b1;
      record_q.insert(record_q.size(), rec);
      clear_scan_state();
    end
  endtask

  // Driver: offers queued bytes and feeds the scoreboard on each accepted transfer.
  always @(posedge clk) begin
    file_byte_t item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
      clear_scan_state();
    end else begin
      if (in_tvalid && in_tready) begin
        scan_byte(in_tdata, in_tlast);
        bytes_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (byte_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          item = byte_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= item.data;
          in_tlast  <= item.eof;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and randomizes backpressure.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    logic bad;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.rec_kind        = out_tuser[0];
        got.entry_length    = out_tdata[OUT_W-1:0];
        got.entry_start     = out_tdata[2*OUT_W-1:OUT_W];
        got.entry_end       = out_tdata[3*OUT_W-1:2*OUT_W];
        got.total_residues  = out_tdata[4*OUT_W-1:3*OUT_W];
        got.header_total    = out_tdata[4*OUT_W+HDR_W-1:4*OUT_W];
        got.nucleotide_like = out_tdata[4*OUT_W+HDR_W];
        got.last_rec        = out_tlast;
        if (record_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result kind=%0d len=%0d start=%0d end=%0d",
                     got.rec_kind, got.entry_length, got.entry_start, got.entry_end);
        end else begin
          want = record_q.pop_front();
          bad = (got.rec_kind != want.rec_kind) ||
                (got.entry_length != want.entry_length) ||
                (got.entry_start != want.entry_start) ||
                (got.entry_end != want.entry_end) ||
                (got.total_residues != want.total_residues) ||
                (got.header_total != want.header_total) ||
                (got.nucleotide_like != want.nucleotide_like) ||
                (got.last_rec != want.last_rec);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: expected kind=%0d len=%0d start=%0d end=%0d tot=%0d hdr=%0d nuc=%0d last=%0d",
                       want.rec_kind, want.entry_length, want.entry_start, want.entry_end,
                       want.total_residues, want.header_total, want.nucleotide_like,
                       want.last_rec);
              $display("       actual   kind=%0d len=%0d start=%0d end=%0d tot=%0d hdr=%0d nuc=%0d last=%0d",
                       got.rec_kind, got.entry_length, got.entry_start, got.entry_end,
                       got.total_residues, got.header_total, got.nucleotide_like,
                       got.last_rec);
            end
          end
        end
      end
      out_tready <= !sink_hold && ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Long receiver hold-off while the sender keeps offering bytes.
  initial begin
    sink_hold = 1'b0;
    while (bytes_taken < 300) @(posedge clk);
    sink_hold <= 1'b1;
    repeat (400) @(posedge clk);
    sink_hold <= 1'b0;
  end

  task automatic push_byte(input logic [DATA_W-1:0] b, input logic eof);
    file_byte_t item;
    item.data = b;
    item.eof  = eof;
    byte_q.insert(byte_q.size(), item);
  endtask

  function automatic logic [DATA_W-1:0] pick_residue(input logic nuc_file);
    logic [DATA_W-1:0] c;
    if (nuc_file && $urandom_range(0, 15) != 0) begin
      case ($urandom_range(0, 3))
        0: c = CH_A;
        1: c = CH_C;
        2: c = CH_G;
        default: c = CH_T;
      endcase
    end else begin
      c = CH_A + DATA_W'($urandom_range(0, 25));
    end
    // Lower case in roughly a third of the letters.
    if ($urandom_range(0, 2) == 0) c = c | 8'h20;
    return c;
  endfunction

  task automatic push_eol(ref logic [DATA_W-1:0] q[$]);
    case ($urandom_range(0, 3))
      0: q.insert(q.size(), CH_CR);
      1: begin
        q.insert(q.size(), CH_CR);
        q.insert(q.size(), CH_LF);
      end
      default: q.insert(q.size(), CH_LF);
    endcase
  endtask

  // Builds one file: mostly well-formed FASTA, some broken or pure noise.
  task automatic add_random_file();
    logic [DATA_W-1:0] fb[$];
    logic nuc_file;
    int n_ent;
    int n_lines;
    int n_chars;
    int cut;
    nuc_file = ($urandom_range(0, 2) != 0);
    if ($urandom_range(0, 9) == 0) begin
      n_chars = $urandom_range(1, 30);
      for (int i = 0; i < n_chars; i++) fb.insert(fb.size(), DATA_W'($urandom_range(0, 255)));
    end else begin
      // Residues ahead of the first header.
      if ($urandom_range(0, 4) == 0) begin
        n_chars = $urandom_range(1, 6);
        for (int i = 0; i < n_chars; i++) fb.insert(fb.size(), pick_residue(nuc_file));
        push_eol(fb);
      end
      n_ent = $urandom_range(1, 4);
      for (int e = 0; e < n_ent; e++) begin
        fb.insert(fb.size(), CH_GT);
        n_chars = $urandom_range(0, 8);
        for (int i = 0; i < n_chars; i++) begin
          fb.insert(fb.size(), DATA_W'($urandom_range(8'h21, 8'h7E)));
        end
        push_eol(fb);
        n_lines = $urandom_range(0, 3);
        for (int l = 0; l < n_lines; l++) begin
          n_chars = $urandom_range(1, 12);
          for (int i = 0; i < n_chars; i++) fb.insert(fb.size(), pick_residue(nuc_file));
          push_eol(fb);
        end
      end
      // Broken files: truncated, or a stray byte dropped in.
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, fb.size());
        while (fb.size() > cut) void'(fb.pop_back());
      end else if ($urandom_range(0, 7) == 0) begin
        fb.insert($urandom_range(0, fb.size() - 1), DATA_W'($urandom_range(0, 255)));
      end
      // A header opening on the final byte.
      if ($urandom_range(0, 9) == 0) fb.insert(fb.size(), CH_GT);
    end
    for (int i = 0; i < fb.size(); i++) push_byte(fb[i], i == fb.size() - 1);
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || in_tvalid) @(posedge clk);
    while (record_q.size() != 0) @(posedge clk);
  endtask

  // Stimulus and end of run.
  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int target;
    idle_tab  = '{0, 60, 0, 35};
    stall_tab = '{0, 0, 60, 35};
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    bytes_taken    = 0;
    mismatches     = 0;
    @(posedge rst_n);

    // A one-byte file with all data bits set.
    push_byte(8'hFF, 1'b1);
    // A header opening as the only byte of a file.
    push_byte(CH_GT, 1'b1);
    // Header before residues, a '>' inside a header, CR closing it,
    // mixed case and NUL residues, LF outside a header, a header opening
    // on the final byte.
    push_byte(CH_GT, 1'b0);
    push_byte(CH_GT, 1'b0);
    push_byte(CH_CR, 1'b0);
    push_byte(CH_A, 1'b0);
    push_byte(CH_C | 8'h20, 1'b0);
    push_byte(CH_G | 8'h20, 1'b0);
    push_byte(CH_T, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(CH_LF, 1'b0);
    push_byte(CH_GT, 1'b0);
    push_byte(8'h68, 1'b0);
    push_byte(CH_LF, 1'b0);
    push_byte(8'h4E, 1'b0);
    push_byte(8'h6E, 1'b0);
    push_byte(CH_GT, 1'b1);
    drain();

    // Random files under each idling mix.
    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = idle_tab[p];
      sink_stall_pct = stall_tab[p];
      target = byte_q.size() + 180;
      while (byte_q.size() < target) add_random_file();
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && record_q.size() == 0) begin
      $display("tb_fasta_entry_indexer passed");
    end else begin
      $display("tb_fasta_entry_indexer failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20_000_000;
    $display("tb_fasta_entry_indexer failed");
    $finish;
  end

endmodule

/* sim.f */
src/fei_pkg.sv
src/fei_core.sv
src/fasta_entry_indexer.sv
tb/sv/tb_fasta_entry_indexer.sv
